// ----- rtl/epa_pkg.sv -----
package epa_pkg;

    localparam int NUM_PARTS    = 8;
    localparam int NUM_VERTICES = 65536;

    localparam int PART_W   = $clog2(NUM_PARTS);
    localparam int PART_POW = 2 ** PART_W;
    localparam int VERT_W   = $clog2(NUM_VERTICES);

    localparam int REP_W    = 4;
    localparam int EC_W     = 32;
    localparam int VC_W     = 17;
    localparam int RECIP_W  = 32;
    localparam int ET_W     = EC_W + RECIP_W - 16;
    localparam int VT_W     = VC_W + RECIP_W - 16;
    localparam int SC_W     = ET_W + 4;
    localparam int Q_ONE    = 65536;

    localparam int CHOSEN_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PARTS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_PART    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_BONUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_RECIP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_RECIP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_BONUS  = 3'd6;

    typedef struct packed {
        logic [NUM_PARTS-1:0] memb;
        logic [REP_W-1:0]     rep;
    } vword_t;

    typedef struct packed {
        logic              en;
        logic [PART_W-1:0] part;
        logic [1:0]        vinc;
    } upd_t;

    function automatic logic [EC_W-1:0] ec_inc(input logic [EC_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [VC_W-1:0] vc_add(input logic [VC_W-1:0] c,
                                               input logic [1:0] inc);
        logic [VC_W:0] s;
        s = {1'b0, c} + (VC_W+1)'(inc);
        return s[VC_W] ? {VC_W{1'b1}} : s[VC_W-1:0];
    endfunction

endpackage

// ----- rtl/edge_partition_assigner.sv -----
// Streaming vertex-cut edge partitioner. Each input beat carries one edge
// (two vertex ids); the block scores every partition in use and returns one
// output beat naming the winner, whether each endpoint was new to it, and the
// winner's updated edge and vertex counts. Self-loops produce no output beat.
// Per-vertex membership bits and replica counts live in one synchronous RAM
// with two read ports and one write port; per-partition counters and their
// load terms sit in flip-flops. An edge passes through the RAM read, the
// score computation, then the pick, which writes the first endpoint back and
// issues the result, while the second endpoint is written in the state in
// which the next edge can be accepted. The single RAM write port is why that
// write is deferred; a new edge is taken only then or when idle, and the pick
// waits while an unaccepted output beat is held. After reset the block clears
// all 65536 RAM entries, one per cycle, before it accepts its first edge;
// configuration writes are taken at any time but are meant for an idle block.
module edge_partition_assigner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // src_vertex[15:0], dst_vertex[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_part[2:0], src_added[3], dst_added[4], part_edges[36:5],
    // part_vertices[53:37], zero fill[55:54]
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import epa_pkg::*;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCORE, ST_PICK, ST_WRD} state_t;

    state_t              state_reg;
    logic [VERT_W-1:0]   clr_reg;
    logic [VERT_W-1:0]   src_reg, dst_reg;
    vword_t              srcw_reg, dstw_reg;
    vword_t              fwdw_reg;
    logic                fwd_s_reg, fwd_d_reg;

    logic                out_valid_reg;
    logic [55:0]         out_data_reg;

    logic [3:0]          parts_in_use_reg;
    logic [2:0]          home_part_reg;
    logic [15:0]         home_bonus_reg;
    logic [31:0]         edge_recip_reg;
    logic [31:0]         vert_recip_reg;
    logic                fault_mode_reg;
    logic [19:0]         fault_bonus_reg;

    logic [VERT_W-1:0]   in_src, in_dst;
    logic                accept;
    vword_t              rd_a, rd_b, src_word, dst_word;
    logic                ram_we;
    logic [VERT_W-1:0]   ram_waddr;
    vword_t              ram_wdata;
    logic [PART_W-1:0]   best;
    logic                pick_go;
    logic                sa, da;
    vword_t              srcw_new, dstw_new;
    upd_t                upd;
    logic [EC_W-1:0]     ecnt [NUM_PARTS];
    logic [VC_W-1:0]     vcnt [NUM_PARTS];
    logic [ET_W-1:0]     eterm [NUM_PARTS];
    logic [VT_W-1:0]     vterm [NUM_PARTS];
    logic [EC_W-1:0]     new_ec;
    logic [VC_W-1:0]     new_vc;

    assign in_src    = s_tdata[VERT_W-1:0];
    assign in_dst    = s_tdata[16+VERT_W-1:16];
    assign s_tready  = (state_reg == ST_IDLE) || (state_reg == ST_WRD);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // The second endpoint of the previous edge is written in the same cycle
    // that a new edge is read, so its fresh word is forwarded.
    assign src_word = fwd_s_reg ? fwdw_reg : rd_a;
    assign dst_word = fwd_d_reg ? fwdw_reg : rd_b;

    epa_ram #(.WIDTH($bits(vword_t)), .DEPTH(NUM_VERTICES)) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (in_src),
        .raddr_b (in_dst),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    epa_score u_score (
        .clk            (clk),
        .load           (state_reg == ST_SCORE),
        .src_word       (src_word),
        .dst_word       (dst_word),
        .parts_in_use   (parts_in_use_reg),
        .home_partition (home_part_reg),
        .home_bonus     (home_bonus_reg),
        .fault_mode     (fault_mode_reg),
        .fault_bonus    (fault_bonus_reg),
        .eterm          (eterm),
        .vterm          (vterm),
        .best           (best)
    );

    epa_load u_load (
        .clk          (clk),
        .rst_n        (rst_n),
        .upd          (upd),
        .edge_recip   (edge_recip_reg),
        .vertex_recip (vert_recip_reg),
        .ecnt         (ecnt),
        .vcnt         (vcnt),
        .eterm        (eterm),
        .vterm        (vterm)
    );

    // Pick stage: membership updates, counter update and result word.
    assign pick_go = (state_reg == ST_PICK) && (!out_valid_reg || m_tready);
    assign sa      = !srcw_reg.memb[best];
    assign da      = !dstw_reg.memb[best];

    always_comb
    begin
        srcw_new = srcw_reg;
        dstw_new = dstw_reg;
        if (sa)
        begin
            srcw_new.memb[best] = 1'b1;
            if (!(&srcw_reg.rep))
            begin
                srcw_new.rep = srcw_reg.rep + 1'b1;
            end
        end
        if (da)
        begin
            dstw_new.memb[best] = 1'b1;
            if (!(&dstw_reg.rep))
            begin
                dstw_new.rep = dstw_reg.rep + 1'b1;
            end
        end
    end

    assign upd.en   = pick_go;
    assign upd.part = best;
    assign upd.vinc = 2'(sa) + 2'(da);
    assign new_ec   = ec_inc(ecnt[best]);
    assign new_vc   = vc_add(vcnt[best], upd.vinc);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = src_reg;
        ram_wdata = srcw_new;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_PICK:
            begin
                ram_we = pick_go;
            end
            ST_WRD:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg;
                ram_wdata = dstw_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            src_reg          <= '0;
            dst_reg          <= '0;
            srcw_reg         <= '0;
            dstw_reg         <= '0;
            fwdw_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            fwd_s_reg        <= 1'b0;
            fwd_d_reg        <= 1'b0;
            parts_in_use_reg <= 4'd8;
            home_part_reg    <= 3'd0;
            home_bonus_reg   <= 16'd6554;
            edge_recip_reg   <= 32'd65536;
            vert_recip_reg   <= 32'd65536;
            fault_mode_reg   <= 1'b0;
            fault_bonus_reg  <= 20'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_PARTS_IN_USE: parts_in_use_reg <= cfg_data[3:0];
                    REG_HOME_PART:    home_part_reg    <= cfg_data[2:0];
                    REG_HOME_BONUS:   home_bonus_reg   <= cfg_data[15:0];
                    REG_EDGE_RECIP:   edge_recip_reg   <= cfg_data;
                    REG_VERT_RECIP:   vert_recip_reg   <= cfg_data;
                    REG_FAULT_MODE:   fault_mode_reg   <= cfg_data[0];
                    REG_FAULT_BONUS:  fault_bonus_reg  <= cfg_data[19:0];
                    default:          ;
                endcase
            end

            // A beat taken while the pick issues a new one keeps the flag high.
            if (out_valid_reg && m_tready && !pick_go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg) inside
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE, ST_WRD:
                begin
                    if (accept && in_src != in_dst)
                    begin
                        state_reg <= ST_SCORE;
                        src_reg   <= in_src;
                        dst_reg   <= in_dst;
                        fwd_s_reg <= (state_reg == ST_WRD) && (in_src == dst_reg);
                        fwd_d_reg <= (state_reg == ST_WRD) && (in_dst == dst_reg);
                        fwdw_reg  <= dstw_reg;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCORE:
                begin
                    srcw_reg  <= src_word;
                    dstw_reg  <= dst_word;
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (pick_go)
                    begin
                        srcw_reg      <= srcw_new;
                        dstw_reg      <= dstw_new;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {2'b00, new_vc, new_ec, da, sa,
                                          CHOSEN_W'(best)};
                        state_reg     <= ST_WRD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/epa_ram.sv -----
module epa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/epa_load.sv -----
module epa_load (
    input  logic                         clk,
    input  logic                         rst_n,
    input  epa_pkg::upd_t                upd,
    input  logic [epa_pkg::RECIP_W-1:0]  edge_recip,
    input  logic [epa_pkg::RECIP_W-1:0]  vertex_recip,
    output logic [epa_pkg::EC_W-1:0]     ecnt [epa_pkg::NUM_PARTS],
    output logic [epa_pkg::VC_W-1:0]     vcnt [epa_pkg::NUM_PARTS],
    output logic [epa_pkg::ET_W-1:0]     eterm [epa_pkg::NUM_PARTS],
    output logic [epa_pkg::VT_W-1:0]     vterm [epa_pkg::NUM_PARTS]
);
    import epa_pkg::*;

    logic [EC_W-1:0] ecnt_reg [NUM_PARTS];
    logic [VC_W-1:0] vcnt_reg [NUM_PARTS];
    logic [ET_W-1:0] eterm_reg [NUM_PARTS];
    logic [VT_W-1:0] vterm_reg [NUM_PARTS];

    // Counters saturate; the load terms follow them in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PARTS; p++)
            begin
                ecnt_reg[p] <= '0;
                vcnt_reg[p] <= '0;
            end
        end
        else if (upd.en)
        begin
            ecnt_reg[upd.part] <= ec_inc(ecnt_reg[upd.part]);
            vcnt_reg[upd.part] <= vc_add(vcnt_reg[upd.part], upd.vinc);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            eterm_reg[p] <= ET_W'((64'(ecnt_reg[p]) * 64'(edge_recip)) >> 16);
            vterm_reg[p] <= VT_W'((64'(vcnt_reg[p]) * 64'(vertex_recip)) >> 16);
        end
    end

    assign ecnt  = ecnt_reg;
    assign vcnt  = vcnt_reg;
    assign eterm = eterm_reg;
    assign vterm = vterm_reg;

endmodule

// ----- rtl/epa_score.sv -----
module epa_score (
    input  logic                        clk,
    input  logic                        load,
    input  epa_pkg::vword_t             src_word,
    input  epa_pkg::vword_t             dst_word,
    input  logic [3:0]                  parts_in_use,
    input  logic [2:0]                  home_partition,
    input  logic [15:0]                 home_bonus,
    input  logic                        fault_mode,
    input  logic [19:0]                 fault_bonus,
    input  logic [epa_pkg::ET_W-1:0]    eterm [epa_pkg::NUM_PARTS],
    input  logic [epa_pkg::VT_W-1:0]    vterm [epa_pkg::NUM_PARTS],
    output logic [epa_pkg::PART_W-1:0]  best
);
    import epa_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [PART_W-1:0]      idx;
        logic signed [SC_W-1:0] sc;
    } cand_t;

    logic signed [SC_W-1:0] sc_reg [NUM_PARTS];
    logic [NUM_PARTS-1:0]   ok_reg;
    logic signed [SC_W-1:0] sc_next [NUM_PARTS];
    logic [NUM_PARTS-1:0]   ok_next;
    cand_t                  node [2*PART_POW];

    function automatic logic signed [SC_W-1:0] ep_term(input logic held,
                                                       input logic [REP_W-1:0] rep,
                                                       input logic fm,
                                                       input logic [19:0] fb);
        logic signed [SC_W-1:0] t;
        t = '0;
        if (!held)
        begin
            t = -SC_W'(Q_ONE);
            if (fm && rep == REP_W'(1))
            begin
                t = t + SC_W'(fb);
            end
        end
        return t;
    endfunction

    always_comb
    begin
        int n;
        n = int'(parts_in_use);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > NUM_PARTS)
        begin
            n = NUM_PARTS;
        end
        for (int p = 0; p < NUM_PARTS; p++)
        begin
            ok_next[p] = (p < n);
            sc_next[p] = ep_term(src_word.memb[p], src_word.rep, fault_mode, fault_bonus)
                       + ep_term(dst_word.memb[p], dst_word.rep, fault_mode, fault_bonus)
                       - SC_W'(eterm[p]) - SC_W'(vterm[p])
                       + ((int'(home_partition) == p) ? SC_W'(home_bonus) : SC_W'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sc_reg <= sc_next;
            ok_reg <= ok_next;
        end
    end

    // Max tree; on equal scores the lower index wins.
    always_comb
    begin
        for (int i = 0; i < PART_POW; i++)
        begin
            if (i < NUM_PARTS)
            begin
                node[PART_POW+i] = {ok_reg[i], PART_W'(i), sc_reg[i]};
            end
            else
            begin
                node[PART_POW+i] = '0;
            end
        end
        node[0] = '0;
        for (int k = PART_POW - 1; k >= 1; k--)
        begin
            if (!node[2*k+1].ok || (node[2*k].ok && node[2*k].sc >= node[2*k+1].sc))
            begin
                node[k] = node[2*k];
            end
            else
            begin
                node[k] = node[2*k+1];
            end
        end
    end

    assign best = node[1].idx;

endmodule

// ----- bench/tb_edge_partition_assigner.sv -----
`timescale 1ns / 1ps

module tb_edge_partition_assigner;
    import epa_pkg::*;

    // Expected content of one output beat.
    typedef struct {
        logic [2:0]  part;
        logic        src_new;
        logic        dst_new;
        logic [31:0] edges;
        logic [16:0] verts;
    } assignment_t;

    // Partition predictor and the queue of assignments still owed by the block.
    class assignment_board;
        logic [3:0]  cfg_parts;
        logic [2:0]  cfg_home;
        logic [15:0] cfg_home_bonus;
        logic [31:0] cfg_edge_recip;
        logic [31:0] cfg_vert_recip;
        logic        cfg_fault;
        logic [19:0] cfg_fault_bonus;
        logic [NUM_PARTS-1:0] member [NUM_VERTICES];
        logic [3:0]  replicas [NUM_VERTICES];
        logic [31:0] edge_cnt [NUM_PARTS];
        logic [16:0] vert_cnt [NUM_PARTS];
        assignment_t pending[$];
        int errors;

        function new();
            cfg_parts = 8;
            cfg_home = 0;
            cfg_home_bonus = 6554;
            cfg_edge_recip = 65536;
            cfg_vert_recip = 65536;
            cfg_fault = 0;
            cfg_fault_bonus = 0;
            foreach (member[i])
            begin
                member[i] = '0;
                replicas[i] = '0;
            end
            foreach (edge_cnt[i])
            begin
                edge_cnt[i] = '0;
                vert_cnt[i] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_PARTS_IN_USE: cfg_parts = val[3:0];
                REG_HOME_PART:    cfg_home = val[2:0];
                REG_HOME_BONUS:   cfg_home_bonus = val[15:0];
                REG_EDGE_RECIP:   cfg_edge_recip = val;
                REG_VERT_RECIP:   cfg_vert_recip = val;
                REG_FAULT_MODE:   cfg_fault = val[0];
                REG_FAULT_BONUS:  cfg_fault_bonus = val[19:0];
                default: ;
            endcase
        endfunction

        function longint lack_term(logic [15:0] v, int p);
            longint t;
            t = 0;
            if (!member[v][p])
            begin
                t = -65536;
                if (cfg_fault && replicas[v] == 1)
                    t += cfg_fault_bonus;
            end
            return t;
        endfunction

        function logic join_part(logic [15:0] v, int p);
            if (member[v][p])
                return 1'b0;
            member[v][p] = 1'b1;
            if (replicas[v] != 4'hF)
                replicas[v]++;
            if (vert_cnt[p] != 17'h1FFFF)
                vert_cnt[p]++;
            return 1'b1;
        endfunction

        // Notes an accepted edge beat and predicts its assignment.
        function void note_edge(logic [15:0] s, logic [15:0] d);
            int n, best;
            longint sc, best_sc;
            assignment_t a;
            if (s == d)
                return;
            n = (cfg_parts == 0) ? 1 : (cfg_parts > NUM_PARTS ? NUM_PARTS : cfg_parts);
            best = 0;
            best_sc = 0;
            for (int p = 0; p < n; p++)
            begin
                sc = lack_term(s, p) + lack_term(d, p);
                sc -= longint'(({32'd0, edge_cnt[p]} * {32'd0, cfg_edge_recip}) >> 16);
                sc -= longint'(({47'd0, vert_cnt[p]} * {32'd0, cfg_vert_recip}) >> 16);
                if (p == cfg_home)
                    sc += cfg_home_bonus;
                if (p == 0 || sc > best_sc)
                begin
                    best_sc = sc;
                    best = p;
                end
            end
            a.src_new = join_part(s, best);
            a.dst_new = join_part(d, best);
            if (edge_cnt[best] != 32'hFFFF_FFFF)
                edge_cnt[best]++;
            a.part = best[2:0];
            a.edges = edge_cnt[best];
            a.verts = vert_cnt[best];
            pending = {pending, a};
        endfunction

        // Checks one output beat against the oldest prediction.
        function void check_beat(logic [55:0] data);
            assignment_t a;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output beat %h", data);
                return;
            end
            a = pending.pop_front();
            if (data[2:0] !== a.part || data[3] !== a.src_new || data[4] !== a.dst_new
                || data[36:5] !== a.edges || data[53:37] !== a.verts
                || data[55:54] !== 2'b00)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected part %0d new %b%b edges %0d verts %0d, got %h",
                             a.part, a.src_new, a.dst_new, a.edges, a.verts, data);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // src_vertex[15:0], dst_vertex[31:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;      // chosen_part, src_added, dst_added, part_edges, part_vertices
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    assignment_board board;
    int send_idle_pct;         // chance in percent that the sender skips a cycle
    int recv_stall_pct;        // chance in percent that the receiver stalls
    bit sim_done;

    edge_partition_assigner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The block clears its vertex RAM after reset, so the limit covers that
    // clear plus every edge sent below at worst-case stalls.
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: a random ready, and every output beat is checked as it lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_beat(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        else
        begin
            m_tready <= 1'b0;
        end
    end

    // Sends one edge beat, inserting random idle cycles before it.
    task automatic send_edge(input logic [15:0] s, input logic [15:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {d, s};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_edge(s, d);
    endtask

    // Waits until all predictions are met, then a margin for a self-loop in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A hot set of vertices makes membership hits and replica effects common.
    task automatic random_edges(input int count);
        logic [15:0] s, d;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                s = 16'($urandom);
                d = ($urandom_range(3) == 0) ? s : 16'($urandom);
            end
            else
            begin
                s = 16'($urandom_range(40));
                d = 16'($urandom_range(40));
            end
            send_edge(s, d);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PARTS_IN_USE;
        cfg_data = '0;
        send_idle_pct = 12;
        recv_stall_pct = 48;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, self-loops and repeated edges.
        send_edge(16'h0000, 16'hFFFF);
        send_edge(16'hFFFF, 16'h0000);
        send_edge(16'h1234, 16'h1234);
        send_edge(16'h0000, 16'h0000);
        send_edge(16'hAAAA, 16'h5555);
        send_edge(16'h5555, 16'hAAAA);
        send_edge(16'h0000, 16'hFFFF);
        for (int i = 1; i < 10; i++)
            send_edge(16'(i), 16'(i + 1));
        drain();

        // Fault bonus on, home outside the partitions in use, extreme reciprocals.
        write_reg(REG_FAULT_MODE, 32'd1);
        write_reg(REG_FAULT_BONUS, 32'hFFFFF);
        write_reg(REG_PARTS_IN_USE, 32'd3);
        write_reg(REG_HOME_PART, 32'd7);
        write_reg(REG_HOME_BONUS, 32'hFFFF);
        write_reg(REG_EDGE_RECIP, 32'hFFFF_FFFF);
        write_reg(REG_VERT_RECIP, 32'd0);
        for (int i = 0; i < 6; i++)
            send_edge(16'(i), 16'(100 + i));
        drain();

        write_reg(REG_PARTS_IN_USE, 32'd0);
        random_edges(40);
        drain();
        write_reg(REG_PARTS_IN_USE, 32'd15);
        write_reg(REG_HOME_PART, 32'd3);
        write_reg(REG_FAULT_BONUS, 32'd40000);
        write_reg(REG_EDGE_RECIP, 32'd0);
        write_reg(REG_VERT_RECIP, 32'hFFFF_FFFF);
        random_edges(180);
        drain();

        send_idle_pct = 48;
        recv_stall_pct = 12;
        write_reg(REG_PARTS_IN_USE, 32'd1);
        write_reg(REG_FAULT_MODE, 32'd0);
        write_reg(REG_HOME_BONUS, 32'd0);
        random_edges(60);
        drain();
        write_reg(REG_PARTS_IN_USE, 32'd8);
        write_reg(REG_HOME_PART, 32'd0);
        write_reg(REG_HOME_BONUS, 32'd6554);
        write_reg(REG_EDGE_RECIP, 32'd65536);
        write_reg(REG_VERT_RECIP, 32'd65536);
        random_edges(150);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_FAULT_MODE, 32'd1);
        write_reg(REG_FAULT_BONUS, 32'd0);
        write_reg(REG_PARTS_IN_USE, 32'd5);
        random_edges(170);
        drain();

        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
